// File: src/brfps_pkg.sv
// Package for the circular byte FIFO with peek and skip.
// Holds the item structs, the operation codes and the parameter defaults.
// No dependencies.
package brfps_pkg;

    localparam int DEPTH_DEF       = 256;
    localparam int MAX_REQUEST_DEF = 64;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int FILL_W  = 9;
    localparam int CAP_W   = 9;

    // capacity register value after reset
    localparam int CAP_RESET = 256;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_PEEK  = 2'd2,
        KIND_SKIP  = 2'd3
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [COUNT_W-1:0]  request_count;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                byte_valid;
        logic                last;
        logic [COUNT_W-1:0]  moved_count;
        logic [FILL_W-1:0]   fill_level;
    } t_out_item;

endpackage

// File: src/byte_ring_fifo_peek_skip.sv
// Top level of the circular byte FIFO with read, peek and skip.
// Depends on brfps_pkg (item structs, operation codes, defaults).
// Holds the byte store, the ring pointers and the read sequencer.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-----------------------------
//  in      | in  | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | out | o_out_valid / i_out_ready | o_out_item (t_out_item)
//  cfg     | in  | i_cfg_valid / o_cfg_ready | i_cfg_data (capacity, 9 bits)
//
// Flow: a write, a skip or an empty request leaves one item in the output
// register. A read or peek of n bytes issues one store read per cycle from the
// single read port while the output is not stalled, and so gives n items;
// the next input item is taken only once the last store read has moved on
// to the output register.
// Reset: pointers and fill count cleared, capacity set to its reset value; the
// store itself is not cleared and needs no clearing pass.
// Stalls: a stalled output holds one item in the output register and one in
// the store read register; the sequencer waits until either frees up.
module byte_ring_fifo_peek_skip #(
    parameter int DEPTH       = brfps_pkg::DEPTH_DEF,
    parameter int MAX_REQUEST = brfps_pkg::MAX_REQUEST_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  brfps_pkg::t_in_item         i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output brfps_pkg::t_out_item        o_out_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [brfps_pkg::CAP_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(DEPTH);           // ring index width
    localparam int CW = $clog2(DEPTH + 1);       // holds DEPTH itself
    localparam int MW = (CW > brfps_pkg::COUNT_W) ? CW : brfps_pkg::COUNT_W;
    localparam int EW = (CW > brfps_pkg::CAP_W) ? CW : brfps_pkg::CAP_W;
    localparam int CAP_RST_EFF = (DEPTH < brfps_pkg::CAP_RESET) ?
                                 DEPTH : brfps_pkg::CAP_RESET;

    localparam logic [brfps_pkg::COUNT_W-1:0] MAX_REQ =
        brfps_pkg::COUNT_W'(MAX_REQUEST);

    // byte store: one write port, one registered read port
    logic [brfps_pkg::BYTE_W-1:0] mem_store [DEPTH];
    logic [brfps_pkg::BYTE_W-1:0] r_rdata;

    // ring state
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_held, n_held;
    logic [CW-1:0] r_cap,  n_cap;

    // read sequencer
    brfps_pkg::t_state             r_state, n_state;
    logic [IW-1:0]                 r_idx,  n_idx;
    logic [brfps_pkg::COUNT_W-1:0] r_left, n_left;
    logic [brfps_pkg::COUNT_W-1:0] r_moved, n_moved;
    logic                          r_rd_pend, n_rd_pend;
    logic                          r_rd_last, n_rd_last;

    // output register
    logic                  r_out_valid, n_out_valid;
    brfps_pkg::t_out_item  r_out, n_out;

    // store access controls
    logic          wr_en;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    logic                          out_free;
    logic                          in_acc;
    logic [brfps_pkg::COUNT_W-1:0] req_sat;
    logic [brfps_pkg::COUNT_W-1:0] n_take;
    logic [IW-1:0]                 head_adv;
    logic [CW:0]                   head_sum;

    // step an index by one, wrapping at the capacity in use
    function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] idx,
                                                input logic [CW-1:0] cap);
        logic [CW-1:0] inc;
        inc = CW'(idx) + CW'(1);
        return (inc >= cap) ? '0 : IW'(inc);
    endfunction

    // capacity as written, clamped into 1 .. DEPTH
    function automatic logic [CW-1:0] eff_cap(input logic [brfps_pkg::CAP_W-1:0] v);
        logic [EW-1:0] ve;
        ve = EW'(v);
        if (ve == '0) begin
            return CW'(1);
        end else if (ve > EW'(DEPTH)) begin
            return CW'(DEPTH);
        end
        return CW'(ve);
    endfunction

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == brfps_pkg::ST_IDLE) && !r_rd_pend && out_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // request clipped to the limit, then to the fill level
    always_comb begin
        logic [MW-1:0] held_m;
        logic [MW-1:0] req_m;
        req_sat = (i_in_item.request_count > MAX_REQ) ? MAX_REQ
                                                     : i_in_item.request_count;
        held_m  = MW'(r_held);
        req_m   = MW'(req_sat);
        n_take  = (held_m < req_m) ? brfps_pkg::COUNT_W'(held_m) : req_sat;
        // head + n stays below twice the capacity: one compare and subtract
        head_sum = (CW + 1)'(r_head) + (CW + 1)'(n_take);
        if (head_sum >= (CW + 1)'(r_cap)) begin
            head_sum = head_sum - (CW + 1)'(r_cap);
        end
        head_adv = IW'(head_sum);
    end

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_held      = r_held;
        n_cap       = r_cap;
        n_state     = r_state;
        n_idx       = r_idx;
        n_left      = r_left;
        n_moved     = r_moved;
        n_rd_pend   = r_rd_pend;
        n_rd_last   = r_rd_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_idx;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // store read data moves on to the output register
        if (r_rd_pend && out_free) begin
            n_out_valid            = 1'b1;
            n_out.out_byte         = r_rdata;
            n_out.byte_valid       = 1'b1;
            n_out.last             = r_rd_last;
            n_out.moved_count      = r_moved;
            n_out.fill_level       = brfps_pkg::FILL_W'(r_held);
            n_rd_pend              = 1'b0;
        end

        unique case (r_state)
            brfps_pkg::ST_STREAM: begin
                if (!r_rd_pend || out_free) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_idx;
                    n_rd_pend = 1'b1;
                    n_rd_last = (r_left == brfps_pkg::COUNT_W'(1));
                    n_idx     = wrap_next(r_idx, r_cap);
                    n_left    = r_left - brfps_pkg::COUNT_W'(1);
                    if (r_left == brfps_pkg::COUNT_W'(1)) begin
                        n_state = brfps_pkg::ST_IDLE;
                    end
                end
            end
            brfps_pkg::ST_IDLE: begin
                if (in_acc) begin
                    // single-result items unless a read or peek finds bytes
                    n_out.out_byte    = '0;
                    n_out.byte_valid  = 1'b0;
                    n_out.last        = 1'b1;
                    n_out.moved_count = '0;
                    n_out.fill_level  = brfps_pkg::FILL_W'(r_held);
                    unique case (i_in_item.kind)
                        brfps_pkg::KIND_WRITE: begin
                            n_out_valid = 1'b1;
                            if (r_held < r_cap) begin
                                wr_en             = 1'b1;
                                n_tail            = wrap_next(r_tail, r_cap);
                                n_held            = r_held + CW'(1);
                                n_out.moved_count = brfps_pkg::COUNT_W'(1);
                                n_out.fill_level  = brfps_pkg::FILL_W'(n_held);
                            end
                        end
                        brfps_pkg::KIND_SKIP: begin
                            n_out_valid       = 1'b1;
                            n_head            = head_adv;
                            n_held            = r_held - CW'(n_take);
                            n_out.moved_count = n_take;
                            n_out.fill_level  = brfps_pkg::FILL_W'(n_held);
                        end
                        brfps_pkg::KIND_READ, brfps_pkg::KIND_PEEK: begin
                            if (n_take == '0) begin
                                n_out_valid = 1'b1;
                            end else begin
                                // first store read goes out in the accept cycle
                                rd_en     = 1'b1;
                                rd_addr   = r_head;
                                n_rd_pend = 1'b1;
                                n_rd_last = (n_take == brfps_pkg::COUNT_W'(1));
                                n_idx     = wrap_next(r_head, r_cap);
                                n_left    = n_take - brfps_pkg::COUNT_W'(1);
                                n_moved   = n_take;
                                if (n_take != brfps_pkg::COUNT_W'(1)) begin
                                    n_state = brfps_pkg::ST_STREAM;
                                end
                                if (i_in_item.kind == brfps_pkg::KIND_READ) begin
                                    n_head = head_adv;
                                    n_held = r_held - CW'(n_take);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        // capacity write empties the ring
        if (i_cfg_valid) begin
            n_cap  = eff_cap(i_cfg_data);
            n_head = '0;
            n_tail = '0;
            n_held = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_held      <= '0;
            r_cap       <= CW'(CAP_RST_EFF);
            r_state     <= brfps_pkg::ST_IDLE;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_held      <= n_held;
            r_cap       <= n_cap;
            r_state     <= n_state;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_left    <= n_left;
        r_moved   <= n_moved;
        r_rd_last <= n_rd_last;
        r_out     <= n_out;
    end

    // byte store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_store[r_tail] <= i_in_item.data_byte;
        end
        if (rd_en) begin
            r_rdata <= mem_store[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_held_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= r_cap)
        else $error("fill count above capacity");

    a_ptr_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_head) < r_cap) && (CW'(r_tail) < r_cap))
        else $error("ring pointer beyond capacity");

    a_stream_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == brfps_pkg::ST_STREAM) |-> (r_left != '0))
        else $error("sequencer streaming with no bytes left");

    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_pend && r_out_valid && !i_out_ready) |=> ($stable(r_rdata) && r_rd_pend))
        else $error("pending store read lost under stall");
`endif

endmodule
